@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Each check is sampled on the rising clock edge and is disabled while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/crit_pkg.sv @@
package crit_pkg;

  localparam int unsigned TICK_W = 64;
  localparam int unsigned RATE_W = 32;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DAYS_W = 16;
  localparam int unsigned TOTAL_W = 32;

  // Register index decoded from paddr[2].
  localparam logic REG_TICK_RATE = 1'b0;

  localparam logic [TICK_W-1:0] ONE_SEC_NS = 64'd1000000000;
  localparam logic [TICK_W-1:0] NS_MAX_FRAC = 64'd999999999;
  localparam logic [RATE_W-1:0] DEFAULT_RATE_HZ = 32'd24000000;
  localparam logic [31:0] SEC_PER_DAY = 32'd86400;
  localparam logic [20:0] DAYS_PER_ERA = 21'd146097;
  localparam logic [20:0] EPOCH_DAYS = 21'd719468;
  localparam logic [11:0] YEAR_BASE = 12'd2000;
  localparam logic [11:0] YEARS_PER_ERA = 12'd400;

  // Day of year at the first of the month, with March as month zero.
  function automatic logic [8:0] month_start_doy(input logic [3:0] mp);
    logic [8:0] doy;
    case (mp)
      4'd0:    doy = 9'd0;
      4'd1:    doy = 9'd31;
      4'd2:    doy = 9'd61;
      4'd3:    doy = 9'd92;
      4'd4:    doy = 9'd122;
      4'd5:    doy = 9'd153;
      4'd6:    doy = 9'd184;
      4'd7:    doy = 9'd214;
      4'd8:    doy = 9'd245;
      4'd9:    doy = 9'd275;
      4'd10:   doy = 9'd306;
      4'd11:   doy = 9'd337;
      4'd12:   doy = 9'd367;
      4'd13:   doy = 9'd398;
      default: doy = 9'd0;
    endcase
    return doy;
  endfunction

  // Whole centuries within a 400-year era.
  function automatic logic [1:0] era_centuries(input logic [8:0] yoe);
    logic [1:0] c;
    if (yoe >= 9'd300) begin
      c = 2'd3;
    end else if (yoe >= 9'd200) begin
      c = 2'd2;
    end else if (yoe >= 9'd100) begin
      c = 2'd1;
    end else begin
      c = 2'd0;
    end
    return c;
  endfunction

endpackage

@@ rtl/crit_div.sv @@
module crit_div import crit_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TICK_W-1:0] dividend_i,
  input  logic [RATE_W-1:0] divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [TICK_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(TICK_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TICK_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RATE_W-1:0] rem_q, rem_d;
  logic [TICK_W-1:0] quo_q, quo_d;
  logic [RATE_W:0]   trial;
  logic              fits;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of quo_q from the top while quotient bits enter from the bottom.
  assign trial = {rem_q, quo_q[TICK_W-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? RATE_W'(trial - {1'b0, divisor_i}) : trial[RATE_W-1:0];
      quo_d = {quo_q[TICK_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/calendar_rtc_interpolated_time.sv @@
// Channel  Handshake                Payload
// in       in_valid_i / in_stall_o  six RTC bytes, tick_now_i, read_ok_i
// out      out_valid_o / out_stall_i  time_ns_o, reanchored_o
// cfg      APB psel/penable/pwrite  tick_rate_hz at byte address 0
//
// A failed read goes straight to ST_DONE; a read that sets a new anchor first
// passes ST_DAYS to ST_CMP, and an interpolated read then ST_MLO to ST_CLAMP.
// One 32x32 multiplier is shared by the SEC_PER_DAY and ONE_SEC_NS products.
// Reset clears the anchor and the last given time and sets the rate to 24 MHz.
// The input is stalled from acceptance until the result is handed to the
// output register, which waits there while out_stall_i is high.
`include "assert_macros.svh"

module calendar_rtc_interpolated_time import crit_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        seconds_byte_i,
  input  logic [7:0]        minutes_byte_i,
  input  logic [7:0]        hours_byte_i,
  input  logic [7:0]        day_byte_i,
  input  logic [7:0]        month_byte_i,
  input  logic [7:0]        year_byte_i,
  input  logic [TICK_W-1:0] tick_now_i,
  input  logic              read_ok_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [TICK_W-1:0] time_ns_o,
  output logic              reanchored_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DAYS  = 4'd1;
  localparam logic [3:0] ST_MDAY  = 4'd2;
  localparam logic [3:0] ST_TOD   = 4'd3;
  localparam logic [3:0] ST_MNS   = 4'd4;
  localparam logic [3:0] ST_CMP   = 4'd5;
  localparam logic [3:0] ST_MLO   = 4'd6;
  localparam logic [3:0] ST_MHI   = 4'd7;
  localparam logic [3:0] ST_DLOAD = 4'd8;
  localparam logic [3:0] ST_DIV   = 4'd9;
  localparam logic [3:0] ST_SUM   = 4'd10;
  localparam logic [3:0] ST_CLAMP = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  logic [3:0]          state_q, state_d;
  logic [RATE_W-1:0]   rate_q;
  logic [TICK_W-1:0]   last_given_q, last_given_d;
  logic [TICK_W-1:0]   anchor_ns_q, anchor_ns_d;
  logic [TICK_W-1:0]   anchor_ticks_q, anchor_ticks_d;
  logic                anchor_valid_q, anchor_valid_d;
  logic                out_valid_q, out_valid_d;

  logic [5:0]          sec_q, min_q, yr_q;
  logic [4:0]          hour_q, day_q;
  logic [3:0]          mon_q;
  logic [TICK_W-1:0]   tick_q;
  logic [DAYS_W-1:0]   days_q;
  logic [TOTAL_W-1:0]  total_q;
  logic [TICK_W-1:0]   mul_q;
  logic [TICK_W-1:0]   dticks_q;
  logic [TICK_W-1:0]   lo_q;
  logic [TICK_W-1:0]   ns_q;
  logic [TICK_W-1:0]   res_ns_q, res_ns_d;
  logic                res_re_q, res_re_d;
  logic [TICK_W-1:0]   time_ns_q;
  logic                reanchored_q;

  logic                accept;
  logic                out_free;
  logic                cfg_write;
  logic [RATE_W-1:0]   rate_eff;

  logic [31:0]         mul_a, mul_b;
  logic                div_start;
  logic                div_busy;
  logic                div_done;
  logic [TICK_W-1:0]   div_quo;
  logic [TICK_W-1:0]   div_num;
  logic [TICK_W-1:0]   frac_ns;

  logic                early;
  logic [4:0]          mon_full;
  logic [3:0]          mp;
  logic [11:0]         year_adj;
  logic                era_low;
  logic [8:0]          yoe;
  logic [8:0]          doy;
  logic [20:0]         era_days;
  logic [20:0]         doe;
  logic [20:0]         days_sum;
  logic [16:0]         tod;

  assign accept    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign cfg_write = psel && penable && pwrite && pready;
  assign rate_eff  = (rate_q == '0) ? DEFAULT_RATE_HZ : rate_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TICK_RATE) ? rate_q : 32'd0;

  // Days from civil date. The year lies in 1999..2063 once January and
  // February are counted into the previous year, so the era is 4 or 5.
  always_comb begin
    early    = mon_q <= 4'd1;
    mon_full = {1'b0, mon_q} + 5'd1;
    mp       = early ? 4'(mon_full + 5'd9) : 4'(mon_full - 5'd3);
    year_adj = YEAR_BASE + {6'd0, yr_q} - {11'd0, early};
    era_low  = year_adj < YEAR_BASE;
    yoe      = era_low ? 9'(year_adj - 4 * YEARS_PER_ERA) : 9'(year_adj - 5 * YEARS_PER_ERA);
    doy      = month_start_doy(mp) + {4'd0, day_q};
    era_days = era_low ? 21'(4 * DAYS_PER_ERA) : 21'(5 * DAYS_PER_ERA);
    doe      = 21'({12'd0, yoe} * 21'd365) + {14'd0, yoe[8:2]}
               - {19'd0, era_centuries(yoe)} + {12'd0, doy};
    days_sum = era_days + doe - EPOCH_DAYS;
  end

  assign tod = 17'({12'd0, hour_q} * 17'd3600) + 17'({11'd0, min_q} * 17'd60)
               + {11'd0, sec_q};

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state_q)
      ST_MDAY: begin
        mul_a = {{(32 - DAYS_W){1'b0}}, days_q};
        mul_b = SEC_PER_DAY;
      end
      ST_MNS: begin
        mul_a = total_q;
        mul_b = ONE_SEC_NS[31:0];
      end
      ST_MHI: begin
        mul_a = dticks_q[63:32];
        mul_b = ONE_SEC_NS[31:0];
      end
      default: begin
        mul_a = dticks_q[31:0];
        mul_b = ONE_SEC_NS[31:0];
      end
    endcase
  end

  // Only the low half of the upper partial product survives the 64-bit wrap.
  assign div_num   = lo_q + {mul_q[31:0], 32'd0};
  assign div_start = state_q == ST_DLOAD;
  assign frac_ns   = (div_quo > NS_MAX_FRAC) ? NS_MAX_FRAC : div_quo;

  crit_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (rate_eff),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d        = state_q;
    last_given_d   = last_given_q;
    anchor_ns_d    = anchor_ns_q;
    anchor_ticks_d = anchor_ticks_q;
    anchor_valid_d = anchor_valid_q;
    res_ns_d       = res_ns_q;
    res_re_d       = res_re_q;
    out_valid_d    = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (read_ok_i) begin
            state_d = ST_DAYS;
          end else begin
            res_ns_d = last_given_q;
            res_re_d = 1'b0;
            state_d  = ST_DONE;
          end
        end
      end
      ST_DAYS:  state_d = ST_MDAY;
      ST_MDAY:  state_d = ST_TOD;
      ST_TOD:   state_d = ST_MNS;
      ST_MNS:   state_d = ST_CMP;
      ST_CMP: begin
        last_given_d = mul_q;
        if (!anchor_valid_q || mul_q != anchor_ns_q) begin
          anchor_ns_d    = mul_q;
          anchor_ticks_d = tick_q;
          anchor_valid_d = 1'b1;
          res_ns_d       = mul_q;
          res_re_d       = 1'b1;
          state_d        = ST_DONE;
        end else begin
          state_d = ST_MLO;
        end
      end
      ST_MLO:   state_d = ST_MHI;
      ST_MHI:   state_d = ST_DLOAD;
      ST_DLOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM:   state_d = ST_CLAMP;
      ST_CLAMP: begin
        // The sum can only fall below the last value when it wraps.
        if (ns_q < last_given_q) begin
          res_ns_d = last_given_q;
        end else begin
          res_ns_d     = ns_q;
          last_given_d = ns_q;
        end
        res_re_d = 1'b0;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      rate_q         <= DEFAULT_RATE_HZ;
      last_given_q   <= '0;
      anchor_ns_q    <= '0;
      anchor_ticks_q <= '0;
      anchor_valid_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      last_given_q   <= last_given_d;
      anchor_ns_q    <= anchor_ns_d;
      anchor_ticks_q <= anchor_ticks_d;
      anchor_valid_q <= anchor_valid_d;
      out_valid_q    <= out_valid_d;
      if (cfg_write && paddr[2] == REG_TICK_RATE) begin
        rate_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q    <= 64'(mul_a) * 64'(mul_b);
    res_ns_q <= res_ns_d;
    res_re_q <= res_re_d;
    if (accept) begin
      sec_q  <= seconds_byte_i[5:0];
      min_q  <= minutes_byte_i[5:0];
      hour_q <= hours_byte_i[4:0];
      day_q  <= day_byte_i[4:0];
      mon_q  <= month_byte_i[3:0];
      yr_q   <= year_byte_i[5:0];
      tick_q <= tick_now_i;
    end
    if (state_q == ST_DAYS) begin
      days_q <= days_sum[DAYS_W-1:0];
    end
    if (state_q == ST_TOD) begin
      total_q <= mul_q[TOTAL_W-1:0] + {{(TOTAL_W - 17){1'b0}}, tod};
    end
    if (state_q == ST_CMP) begin
      dticks_q <= tick_q - anchor_ticks_q;
    end
    if (state_q == ST_MHI) begin
      lo_q <= mul_q;
    end
    if (state_q == ST_SUM) begin
      ns_q <= anchor_ns_q + frac_ns;
    end
    if (state_q == ST_DONE && out_free) begin
      time_ns_q    <= res_ns_q;
      reanchored_q <= res_re_q;
    end
  end

  assign in_stall_o   = state_q != ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign time_ns_o    = time_ns_q;
  assign reanchored_o = reanchored_q;

  `ASSERT_NEXT(a_accept_blocks, accept, in_stall_o, "input taken again right after an item")
  `ASSERT_SAME(a_div_in_state, div_busy, state_q == ST_DIV, "divider runs outside its state")
  `ASSERT_SAME(a_reanchor_valid, out_valid_o && reanchored_o, anchor_valid_q,
               "new anchor reported without a valid anchor")
  `ASSERT_SAME(a_frac_capped, state_q == ST_CLAMP, (ns_q - anchor_ns_q) < ONE_SEC_NS,
               "interpolated fraction reaches a full second")

endmodule
